[rtl/irc_pkg.sv]
// Shared constants, types and codes for the integer radix conversion block.
package irc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned BASE_W      = 4;
  localparam int unsigned DIGIT_W     = 4;
  // a positive value has at most VALUE_WIDTH-1 digits in base 2
  localparam int unsigned NUM_CELLS   = VALUE_WIDTH - 1;
  // counts through the conversion sweep
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + NUM_CELLS);

  localparam logic [BASE_W-1:0] RADIX_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] RADIX_MAX = BASE_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // control shared by every digit cell
  typedef struct packed {
    logic clear;  // zero digit, carry and step
    logic shift;  // move digits one cell toward the top
  } cell_ctl_t;

endpackage

[rtl/irc_cell.sv]
// One digit cell: clears, doubles its digit plus the carry from below, or shifts.
module irc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irc_pkg::cell_ctl_t           ctl_i,
  input  logic [irc_pkg::BASE_W-1:0]   base_i,
  input  logic                         carry_i,
  input  logic                         step_i,
  input  logic [irc_pkg::DIGIT_W-1:0]  digit_i,
  output logic [irc_pkg::DIGIT_W-1:0]  digit_o,
  output logic                         carry_o,
  output logic                         step_o
);

  logic [irc_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic                        carry_q, carry_d;
  logic                        step_q,  step_d;
  logic [irc_pkg::DIGIT_W:0]   sum;
  logic [irc_pkg::DIGIT_W:0]   diff;
  logic                        ge;

  // 2*d + c stays below 2*base, so one subtract brings it back into range
  assign sum  = {digit_q, 1'b0} + {{irc_pkg::DIGIT_W{1'b0}}, carry_i};
  assign ge   = (sum >= {1'b0, base_i});
  assign diff = sum - {1'b0, base_i};

  always_comb begin
    digit_d = digit_q;
    carry_d = 1'b0;
    step_d  = 1'b0;
    if (ctl_i.clear) begin
      digit_d = '0;
    end else if (ctl_i.shift) begin
      digit_d = digit_i;
    end else if (step_i) begin
      digit_d = ge ? diff[irc_pkg::DIGIT_W-1:0] : sum[irc_pkg::DIGIT_W-1:0];
      carry_d = ge;
      step_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      carry_q <= 1'b0;
      step_q  <= 1'b0;
    end else begin
      digit_q <= digit_d;
      carry_q <= carry_d;
      step_q  <= step_d;
    end
  end

  assign digit_o = digit_q;
  assign carry_o = carry_q;
  assign step_o  = step_q;

endmodule

[rtl/integer_radix_conversion_top.sv]
// Top level: signed integer to base 2..10 digits, most significant digit first.
//
//   channel | direction | ports                                  | handshake
//   --------+-----------+----------------------------------------+-------------------
//   command | in        | base_i, value_i                        | start_i && !busy_o
//   result  | out       | digit_o, last_o, bad_base_o, empty_res_o | valid_o, 1 cycle
//
// A bad base or a value <= 0 gives its single word in the cycle after start.
// For a positive value the value's bits march MSB first into a systolic row of digit
// cells whose carries are registered cell to cell, so the carries of the last bit
// must ripple through every cell to reach the top cell; then the row shifts out one
// digit per cycle, leading zeros dropped. Reset clears control and the cells; the
// receiver cannot stall, so every result word is shown for exactly one cycle.
module integer_radix_conversion_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [irc_pkg::BASE_W-1:0]         base_i,
  input  logic signed [irc_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                               valid_o,
  output logic [irc_pkg::DIGIT_W-1:0]        digit_o,
  output logic                               last_o,
  output logic                               bad_base_o,
  output logic                               empty_res_o
);

  localparam logic [irc_pkg::CNT_W-1:0] CONV_END =
    irc_pkg::CNT_W'(irc_pkg::VALUE_WIDTH + irc_pkg::NUM_CELLS - 2);
  localparam logic [irc_pkg::CNT_W-1:0] EMIT_END =
    irc_pkg::CNT_W'(irc_pkg::NUM_CELLS - 1);
  localparam logic [irc_pkg::CNT_W-1:0] FEED_END =
    irc_pkg::CNT_W'(irc_pkg::VALUE_WIDTH);

  irc_pkg::state_e state_q, state_d;

  logic [irc_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [irc_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic [irc_pkg::BASE_W-1:0]      base_q, base_d;
  logic                            started_q, started_d;

  logic                            valid_q, valid_d;
  logic [irc_pkg::DIGIT_W-1:0]     digit_q, digit_d;
  logic                            last_q, last_d;
  logic                            bad_q, bad_d;
  logic                            empty_q, empty_d;

  logic                            accept;
  logic                            base_bad;
  logic                            value_empty;
  logic                            emit_now;
  irc_pkg::cell_ctl_t              ctl;

  // chain wiring: entry 0 is the feed, entry k+1 is cell k's output
  logic [irc_pkg::DIGIT_W-1:0] chain_digit [irc_pkg::NUM_CELLS+1];
  logic                        chain_carry [irc_pkg::NUM_CELLS+1];
  logic                        chain_step  [irc_pkg::NUM_CELLS+1];
  logic [irc_pkg::DIGIT_W-1:0] top_digit;

  assign accept      = start_i && !busy_o;
  assign base_bad    = (base_i < irc_pkg::RADIX_MIN) || (base_i > irc_pkg::RADIX_MAX);
  assign value_empty = value_i[irc_pkg::VALUE_WIDTH-1] || (value_i == '0);
  assign top_digit   = chain_digit[irc_pkg::NUM_CELLS];
  assign emit_now    = started_q || (top_digit != '0) || (cnt_q == EMIT_END);

  // feed: one value bit per cycle, MSB first, with a step token
  assign chain_digit[0] = '0;
  assign chain_carry[0] = (state_q == irc_pkg::ST_CONV) && (cnt_q < FEED_END)
                          && value_q[irc_pkg::VALUE_WIDTH-1];
  assign chain_step[0]  = (state_q == irc_pkg::ST_CONV) && (cnt_q < FEED_END);

  for (genvar k = 0; k < irc_pkg::NUM_CELLS; k++) begin : g_cell
    irc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .base_i  (base_q),
      .carry_i (chain_carry[k]),
      .step_i  (chain_step[k]),
      .digit_i (chain_digit[k]),
      .digit_o (chain_digit[k+1]),
      .carry_o (chain_carry[k+1]),
      .step_o  (chain_step[k+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      irc_pkg::ST_IDLE: begin
        if (accept && !base_bad && !value_empty) state_d = irc_pkg::ST_CONV;
      end
      irc_pkg::ST_CONV: begin
        if (cnt_q == CONV_END) state_d = irc_pkg::ST_EMIT;
      end
      irc_pkg::ST_EMIT: begin
        if (cnt_q == EMIT_END) state_d = irc_pkg::ST_IDLE;
      end
      default: state_d = irc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy_o    = 1'b1;
    ctl       = '0;
    cnt_d     = cnt_q;
    value_d   = value_q;
    base_d    = base_q;
    started_d = started_q;
    valid_d   = 1'b0;
    digit_d   = '0;
    last_d    = 1'b0;
    bad_d     = 1'b0;
    empty_d   = 1'b0;
    unique case (state_q)
      irc_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cnt_d     = '0;
          started_d = 1'b0;
          value_d   = value_i;
          base_d    = base_i;
          ctl.clear = 1'b1;
          if (base_bad) begin
            valid_d = 1'b1;
            last_d  = 1'b1;
            bad_d   = 1'b1;
          end else if (value_empty) begin
            valid_d = 1'b1;
            last_d  = 1'b1;
            empty_d = 1'b1;
          end
        end
      end
      irc_pkg::ST_CONV: begin
        value_d = value_q << 1;
        cnt_d   = (cnt_q == CONV_END) ? '0 : cnt_q + 1'b1;
      end
      irc_pkg::ST_EMIT: begin
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (emit_now) begin
          started_d = 1'b1;
          valid_d   = 1'b1;
          digit_d   = top_digit;
          last_d    = (cnt_q == EMIT_END);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= irc_pkg::ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    base_q  <= base_d;
    digit_q <= digit_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
    empty_q <= empty_d;
  end

  assign valid_o     = valid_q;
  assign digit_o     = digit_q;
  assign last_o      = last_q;
  assign bad_base_o  = bad_q;
  assign empty_res_o = empty_q;

  // top cell never overflows: a positive value fits in NUM_CELLS digits
  a_no_top_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_step[irc_pkg::NUM_CELLS] |-> !chain_carry[irc_pkg::NUM_CELLS])
    else $error("carry out of top digit cell");

  a_flag_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (bad_base_o || empty_res_o) |-> last_o && (digit_o == '0))
    else $error("flagged word not a lone last word with zero digit");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !bad_base_o && !empty_res_o |-> digit_o < base_q)
    else $error("digit out of range for base");

  a_lead_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(started_q) |-> valid_o && (digit_o != '0))
    else $error("leading zero digit emitted");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the integer radix conversion block.
module tb_top;
  import irc_pkg::*;

  // Quiet-cycle limit: one positive value needs a full conversion sweep with
  // no traffic at all, plus random sender gaps, so allow many times that.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Drain time after the last word; covers a full conversion sweep.
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned NUM_PHASES      = 4;

  // One result word as the block shows it on valid_o.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_base;
    logic               empty_res;
  } digit_word_t;

  // Directed stimulus row. When hand_set is high the single expected word is
  // written in the row; otherwise the predictor works it out.
  typedef struct packed {
    logic [BASE_W-1:0]             radix;
    logic signed [VALUE_WIDTH-1:0] number;
    logic                          hand_set;
    digit_word_t                   word;
  } dir_row_t;

  localparam digit_word_t BAD_WORD   = '{digit: '0, last: 1'b1, bad_base: 1'b1, empty_res: 1'b0};
  localparam digit_word_t EMPTY_WORD = '{digit: '0, last: 1'b1, bad_base: 1'b0, empty_res: 1'b1};
  localparam digit_word_t NO_WORD    = '0;

  localparam int unsigned DIR_N = 23;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    // radix out of range: one flagged word, value ignored even when <= 0
    '{4'd0,  32'sd5,            1'b1, BAD_WORD},
    '{4'd1,  32'sd0,            1'b1, BAD_WORD},
    '{4'd11, -32'sd1,           1'b1, BAD_WORD},
    '{4'd12, 32'sd0,            1'b1, BAD_WORD},
    '{4'd15, 32'sh7FFFFFFF,     1'b1, BAD_WORD},
    // zero or negative value with a valid radix
    '{4'd10, 32'sd0,            1'b1, EMPTY_WORD},
    '{4'd2,  32'sh80000000,     1'b1, EMPTY_WORD},
    '{4'd10, -32'sd1,           1'b1, EMPTY_WORD},
    '{4'd5,  32'shAAAAAAAA,     1'b1, EMPTY_WORD},
    // single-digit values
    '{4'd2,  32'sd1,            1'b1, '{digit: 4'd1, last: 1'b1, bad_base: 1'b0, empty_res: 1'b0}},
    '{4'd10, 32'sd9,            1'b1, '{digit: 4'd9, last: 1'b1, bad_base: 1'b0, empty_res: 1'b0}},
    '{4'd9,  32'sd8,            1'b1, '{digit: 4'd8, last: 1'b1, bad_base: 1'b0, empty_res: 1'b0}},
    // multi-digit runs, predictor checked; base 2 of max gives the longest run
    '{4'd2,  32'sh7FFFFFFF,     1'b0, NO_WORD},
    '{4'd10, 32'sh7FFFFFFF,     1'b0, NO_WORD},
    '{4'd3,  32'sh7FFFFFFF,     1'b0, NO_WORD},
    '{4'd8,  32'sh7FFFFFFF,     1'b0, NO_WORD},
    '{4'd10, 32'sd10,           1'b0, NO_WORD},
    '{4'd2,  32'sd2,            1'b0, NO_WORD},
    '{4'd7,  32'sh55555555,     1'b0, NO_WORD},
    '{4'd4,  32'sh40000000,     1'b0, NO_WORD},
    '{4'd6,  32'sd123456,       1'b0, NO_WORD},
    '{4'd10, 32'sd1000000000,   1'b0, NO_WORD},
    '{4'd9,  32'sh2AAAAAAA,     1'b0, NO_WORD}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [BASE_W-1:0]             base_i;
  logic signed [VALUE_WIDTH-1:0] value_i;
  logic                          valid_o;
  logic [DIGIT_W-1:0]            digit_o;
  logic                          last_o;
  logic                          bad_base_o;
  logic                          empty_res_o;

  // Words still owed by the block, oldest first.
  digit_word_t expected_digits[$];
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;

  integer_radix_conversion_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .base_i     (base_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .digit_o    (digit_o),
    .last_o     (last_o),
    .bad_base_o (bad_base_o),
    .empty_res_o(empty_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Predictor: queue the words that one accepted command produces.
  // Digits come out of repeated remainder/divide LSD first, so build the run
  // with push_front to get MSD first.
  function automatic void convert_to_digits(input logic [BASE_W-1:0] radix,
                                            input logic signed [VALUE_WIDTH-1:0] number);
    logic [VALUE_WIDTH-1:0] rest;
    logic [DIGIT_W-1:0]     msd_first[$];
    digit_word_t            w;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      expected_digits = {expected_digits, BAD_WORD};
    end else if (number <= 0) begin
      expected_digits = {expected_digits, EMPTY_WORD};
    end else begin
      rest = number;
      while (rest != 0) begin
        msd_first.push_front(DIGIT_W'(rest % radix));
        rest = rest / radix;
      end
      foreach (msd_first[k]) begin
        w.digit     = msd_first[k];
        w.last      = (k == msd_first.size() - 1);
        w.bad_base  = 1'b0;
        w.empty_res = 1'b0;
        expected_digits = {expected_digits, w};
      end
    end
  endfunction

  // Random radix: mostly valid so most commands produce real digit runs.
  function automatic logic [BASE_W-1:0] pick_radix();
    if ($urandom_range(99) < 85) return BASE_W'($urandom_range(RADIX_MAX, RADIX_MIN));
    return BASE_W'($urandom_range(15));
  endfunction

  // Random value: mostly positive, spread over short and long digit runs.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return {1'b1, raw[VALUE_WIDTH-2:0]};              // negative
      2, 3:    return VALUE_WIDTH'($urandom_range(999, 1));       // short runs
      4:       return VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 2);
      5:       return {1'b0, {(VALUE_WIDTH-1){1'b1}}} - VALUE_WIDTH'($urandom_range(15));
      default: return {1'b0, raw[VALUE_WIDTH-2:0]};
    endcase
  endfunction

  // Drive one command word at the falling edge, honoring random sender gaps,
  // then hold it until the block takes it (start high, busy low at a rising edge).
  task automatic send_command(input logic [BASE_W-1:0] radix,
                              input logic signed [VALUE_WIDTH-1:0] number,
                              input logic hand_set, input digit_word_t hand_word);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      base_i  <= BASE_W'($urandom);
      value_i <= VALUE_WIDTH'($urandom);
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    base_i  <= radix;
    value_i <= number;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (hand_set) expected_digits = {expected_digits, hand_word};
    else convert_to_digits(radix, number);
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed table, then random phases with sender idle rates
  // of 0, 83, 15 and 0 percent. Between phases the sender waits for a full drain.
  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    base_i        = '0;
    value_i       = '0;
    err_cnt       = 0;
    send_idle_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_command(DIRECTED[i].radix, DIRECTED[i].number,
                   DIRECTED[i].hand_set, DIRECTED[i].word);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // hold off until everything owed has come back
      start_i <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
      case (p)
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 83;
        2:       send_idle_pct = 15;
        default: send_idle_pct = 0;
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_command(pick_radix(), pick_value(), 1'b0, NO_WORD);
      end
    end

    start_i <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_digits.size() != 0) begin
      $error("%0d expected words never arrived", expected_digits.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result checker: every valid_o word is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_words
    digit_word_t want;
    if (rst_ni && valid_o) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected word: digit %0d last %0b bad_base %0b empty_res %0b",
               digit_o, last_o, bad_base_o, empty_res_o);
        err_cnt++;
      end else begin
        want = expected_digits.pop_front();
        if (digit_o !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, digit_o);
          err_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          err_cnt++;
        end
        if (bad_base_o !== want.bad_base) begin
          $error("bad_base: expected %0b, got %0b", want.bad_base, bad_base_o);
          err_cnt++;
        end
        if (empty_res_o !== want.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want.empty_res, empty_res_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too many cycles with neither a command taken nor a word shown.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[filelist.f]
rtl/irc_pkg.sv
rtl/irc_cell.sv
rtl/integer_radix_conversion_top.sv
tb/tb_top.sv
